// File: rtl/kve_pkg.sv
// ----------------------------------------------------------------------------
// kve_pkg: shared types and constants for the keyed Vigenere encryptor
// Letter coding, alphabet length, key store sizing, action codes and the
// command bundle that the control logic sends to the alphabet cells.
// ----------------------------------------------------------------------------
`default_nettype none

package kve_pkg;

  localparam int ALPHA_LEN = 26;
  localparam int LW        = 5;
  localparam int MAX_KEY   = 32;
  localparam int KEY_AW    = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int KEY_CW    = $clog2(MAX_KEY + 1);

  typedef logic [LW-1:0] letter_t;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_KEYWORD = 2'd1,
    ACT_KEYSTRM = 2'd2,
    ACT_ENCRYPT = 2'd3
  } action_t;

  typedef struct packed {
    logic    clear;
    logic    shift;
    letter_t kpos;
    letter_t col_letter;
    letter_t row_letter;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/kve_ram.sv
// ----------------------------------------------------------------------------
// kve_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/kve_cell.sv
// ----------------------------------------------------------------------------
// kve_cell: one entry of the keyed alphabet
// Holds one letter, compares it against the two lookup letters, and on a
// keyword insertion either takes the new letter or its left neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module kve_cell import kve_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire letter_t   idx,
  input  wire letter_t   old_place,
  input  wire letter_t   left,
  output letter_t        value,
  output logic           hit_col,
  output logic           hit_row
);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      value <= idx;
    end else if (cmd.shift) begin
      if (idx == cmd.kpos) begin
        value <= cmd.col_letter;
      end else if (idx > cmd.kpos && idx <= old_place) begin
        value <= left;
      end
    end
  end

  assign hit_col = (value == cmd.col_letter);
  assign hit_row = (value == cmd.row_letter);

endmodule

`default_nettype wire

// File: rtl/keyed_vigenere_encryptor_unit.sv
// ----------------------------------------------------------------------------
// keyed_vigenere_encryptor_unit: keyed Vigenere (Quagmire III) encryptor
// Clear and keystream items never raise busy. A keyword item is located
// among the 26 alphabet cells in S_LOOK, where the cells also shift in
// parallel. An encrypt item goes through S_LOOK, which sums the places of its
// letter and of the key letter from the registered key memory read, and
// S_EMIT, which registers the alphabet readout; its result is strobed as busy
// falls. An encrypt item with no keystream loaded never raises busy. The result
// is shown for exactly one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_vigenere_encryptor_unit import kve_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    action,
  input  wire logic [LW-1:0] letter,
  output logic               strobe,
  output logic [LW-1:0]      cipher_letter,
  output logic               status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EMIT
  } state_t;

  state_t              state;
  action_t             act_q;
  letter_t             let_q;
  letter_t             sum_q;
  letter_t             kpos;
  logic [KEY_CW-1:0]   key_count;
  logic [KEY_AW-1:0]   key_index;

  cell_cmd_t           cmd;
  letter_t             values   [ALPHA_LEN];
  letter_t             left_val [ALPHA_LEN];
  logic [ALPHA_LEN-1:0] hit_col;
  logic [ALPHA_LEN-1:0] hit_row;
  letter_t             col_place;
  letter_t             row_place;
  letter_t             read_val;
  letter_t             key_letter;
  logic [LW:0]         sum_raw;
  logic [LW:0]         sum_mod;
  logic [KEY_CW-1:0]   idx_inc;
  logic                accept;
  logic                key_we;
  logic                kw_go;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign key_we = accept && action_t'(action) == ACT_KEYSTRM
                  && key_count < KEY_CW'(MAX_KEY);

  // A keyword letter moves only if there is room, it is a real letter, and it
  // has not already been placed by an earlier keyword letter.
  assign kw_go = (state == S_LOOK) && (act_q == ACT_KEYWORD)
                 && (kpos < letter_t'(ALPHA_LEN)) && (let_q < letter_t'(ALPHA_LEN))
                 && (col_place >= kpos);

  always_comb begin
    cmd.clear      = accept && action_t'(action) == ACT_CLEAR;
    cmd.shift      = kw_go;
    cmd.kpos       = kpos;
    cmd.col_letter = let_q;
    cmd.row_letter = key_letter;
  end

  always_comb begin
    left_val[0] = values[0];
    for (int i = 1; i < ALPHA_LEN; i++) begin
      left_val[i] = values[i-1];
    end
  end

  for (genvar g = 0; g < ALPHA_LEN; g++) begin : g_cell
    kve_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .idx       (letter_t'(g)),
      .old_place (col_place),
      .left      (left_val[g]),
      .value     (values[g]),
      .hit_col   (hit_col[g]),
      .hit_row   (hit_row[g])
    );
  end

  // The alphabet is always a permutation, so at most one cell hits and the
  // places can be OR-encoded; a letter that is absent encodes as zero.
  always_comb begin
    col_place = '0;
    row_place = '0;
    read_val  = '0;
    for (int i = 0; i < ALPHA_LEN; i++) begin
      col_place = col_place | (letter_t'(i) & {LW{hit_col[i]}});
      row_place = row_place | (letter_t'(i) & {LW{hit_row[i]}});
      if (sum_q == letter_t'(i)) begin
        read_val = values[i];
      end
    end
  end

  assign sum_raw = {1'b0, row_place} + {1'b0, col_place};
  assign sum_mod = (sum_raw >= (LW+1)'(ALPHA_LEN)) ? sum_raw - (LW+1)'(ALPHA_LEN) : sum_raw;
  assign idx_inc = KEY_CW'(key_index) + KEY_CW'(1);

  kve_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_KEY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_count[KEY_AW-1:0]),
    .wdata (letter),
    .raddr (key_index),
    .rdata (key_letter)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kpos      <= '0;
      key_count <= '0;
      key_index <= '0;
      strobe    <= 1'b0;
      status    <= 1'b0;
      cipher_letter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          strobe <= accept && action_t'(action) == ACT_ENCRYPT && key_count == '0;
          if (accept) begin
            act_q <= action_t'(action);
            let_q <= letter;
            case (action_t'(action))
              ACT_CLEAR: begin
                kpos      <= '0;
                key_count <= '0;
                key_index <= '0;
              end
              ACT_KEYWORD: begin
                state <= S_LOOK;
              end
              ACT_KEYSTRM: begin
                if (key_we) begin
                  key_count <= key_count + KEY_CW'(1);
                end
              end
              ACT_ENCRYPT: begin
                if (key_count == '0) begin
                  status        <= 1'b1;
                  cipher_letter <= '0;
                end else begin
                  state <= S_LOOK;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LOOK: begin
          strobe <= 1'b0;
          if (act_q == ACT_ENCRYPT) begin
            sum_q <= sum_mod[LW-1:0];
            if (idx_inc >= key_count) begin
              key_index <= '0;
            end else begin
              key_index <= idx_inc[KEY_AW-1:0];
            end
            state <= S_EMIT;
          end else begin
            if (kw_go) begin
              kpos <= kpos + letter_t'(1);
            end
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          strobe        <= 1'b1;
          status        <= 1'b0;
          cipher_letter <= read_val;
          state         <= S_IDLE;
        end
        default: begin
          strobe <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> cipher_letter == '0)
    else $error("error result carries a nonzero letter");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    key_count <= KEY_CW'(MAX_KEY))
    else $error("key count exceeds the key store depth");

  a_index_ring: assert property (@(posedge clk) disable iff (rst)
    key_count != '0 |-> KEY_CW'(key_index) < key_count)
    else $error("key index outside the loaded keystream");

  a_kpos_max: assert property (@(posedge clk) disable iff (rst)
    kpos <= letter_t'(ALPHA_LEN))
    else $error("keyword position past the alphabet");

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result strobed while an item is still at work");

endmodule

`default_nettype wire

// File: verif/keyed_vigenere_encryptor_unit_tb.sv
// ----------------------------------------------------------------------------
// keyed_vigenere_encryptor_unit_tb: self-checking bench for the encryptor
// Drives clear, keyword, keystream and encrypt items through the start/busy
// handshake, predicts every encrypt result from a local copy of the keyed
// alphabet and key ring, and compares each strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_vigenere_encryptor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kve_pkg::*;

  localparam int NUM_ITEMS      = 1550;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 8;

  typedef struct {
    action_t     act;
    letter_t     ltr;
    int unsigned idle_pct;
    bit          drain;
  } cmd_t;

  typedef struct {
    letter_t cipher;
    logic    status;
  } cipher_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic [1:0]    action = ACT_CLEAR;
  logic [LW-1:0] letter = '0;
  logic          busy;
  logic          strobe;
  logic [LW-1:0] cipher_letter;
  logic          status;

  cmd_t           pending_cmds[$];
  cmd_t           staged_cmds[$];
  cmd_t           active_cmd;
  cipher_result_t expected_ciphers[$];
  int             fail_count = 0;
  int             quiet_cycles = 0;

  // Local copy of the encryptor state.
  letter_t     alpha[ALPHA_LEN];
  int unsigned kw_pos;
  letter_t     key_ring[MAX_KEY];
  int unsigned key_cnt;
  int unsigned key_idx;

  keyed_vigenere_encryptor_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .letter        (letter),
    .strobe        (strobe),
    .cipher_letter (cipher_letter),
    .status        (status)
  );

  always #5 clk = ~clk;

  function automatic int unsigned alpha_place(letter_t l);
    for (int i = 0; i < ALPHA_LEN; i++) begin
      if (alpha[i] == l) return i;
    end
    return 0;
  endfunction

  task automatic clear_cipher_state();
    for (int i = 0; i < ALPHA_LEN; i++) alpha[i] = letter_t'(i);
    for (int i = 0; i < MAX_KEY; i++) key_ring[i] = '0;
    kw_pos  = 0;
    key_cnt = 0;
    key_idx = 0;
  endtask

  // Advances the local state by one accepted item and queues the result
  // that an encrypt item produces.
  task automatic vigenere_apply(cmd_t c);
    int unsigned    old_place;
    int unsigned    row;
    int unsigned    col;
    cipher_result_t res;
    case (c.act)
      ACT_CLEAR: begin
        clear_cipher_state();
      end
      ACT_KEYWORD: begin
        if (kw_pos < ALPHA_LEN && c.ltr < ALPHA_LEN) begin
          old_place = alpha_place(c.ltr);
          // A letter already placed by the keyword leaves everything alone.
          if (old_place >= kw_pos) begin
            for (int j = old_place; j > kw_pos; j--) alpha[j] = alpha[j-1];
            alpha[kw_pos] = c.ltr;
            kw_pos++;
          end
        end
      end
      ACT_KEYSTRM: begin
        if (key_cnt < MAX_KEY) begin
          key_ring[key_cnt] = c.ltr;
          key_cnt++;
        end
      end
      default: begin
        if (key_cnt == 0) begin
          res.cipher = '0;
          res.status = 1'b1;
        end else begin
          if (key_idx >= key_cnt) key_idx = 0;
          col = alpha_place(c.ltr);
          row = alpha_place(key_ring[key_idx]);
          res.cipher = alpha[(row + col) % ALPHA_LEN];
          res.status = 1'b0;
          key_idx++;
          if (key_idx >= key_cnt) key_idx = 0;
        end
        expected_ciphers = {expected_ciphers, res};
      end
    endcase
  endtask

  function automatic letter_t rand_letter();
    if ($urandom_range(7) == 0) return letter_t'($urandom_range(31, 26));
    return letter_t'($urandom_range(25, 0));
  endfunction

  task automatic stage(action_t a, letter_t l);
    cmd_t c;
    c.act      = a;
    c.ltr      = l;
    c.idle_pct = 0;
    c.drain    = 1'b0;
    staged_cmds = {staged_cmds, c};
  endtask

  // Occasionally swaps an item of a sequence for an arbitrary one.
  task automatic stage_seq(action_t a, letter_t l);
    if ($urandom_range(19) == 0) stage(action_t'($urandom_range(3, 0)), letter_t'($urandom));
    else stage(a, l);
  endtask

  task automatic stage_random_sequence();
    letter_t perm[ALPHA_LEN];
    letter_t tmp;
    int unsigned k;
    int unsigned n_key;
    int unsigned n_enc;
    if ($urandom_range(5) != 0) stage_seq(ACT_CLEAR, letter_t'($urandom));
    if ($urandom_range(3) == 0) begin
      // Whole alphabet as keyword, then extra letters past the end.
      for (int i = 0; i < ALPHA_LEN; i++) perm[i] = letter_t'(i);
      for (int i = ALPHA_LEN - 1; i > 0; i--) begin
        k = $urandom_range(i, 0);
        tmp = perm[i];
        perm[i] = perm[k];
        perm[k] = tmp;
      end
      for (int i = 0; i < ALPHA_LEN; i++) stage_seq(ACT_KEYWORD, perm[i]);
      repeat ($urandom_range(4, 1)) stage_seq(ACT_KEYWORD, letter_t'($urandom));
    end else begin
      repeat ($urandom_range(12, 0)) stage_seq(ACT_KEYWORD, rand_letter());
    end
    if ($urandom_range(9) == 0) n_key = 0;
    else if ($urandom_range(4) == 0) n_key = $urandom_range(40, 33);
    else n_key = $urandom_range(12, 1);
    repeat (n_key) stage_seq(ACT_KEYSTRM, rand_letter());
    n_enc = $urandom_range(40, 1);
    repeat (n_enc) stage_seq(ACT_ENCRYPT, rand_letter());
  endtask

  // Driver: start stays high until the item is taken.
  always @(posedge clk) begin : drive_items
    logic start_v;
    if (rst) begin
      start  <= 1'b0;
      action <= ACT_CLEAR;
      letter <= '0;
    end else begin
      start_v = start;
      if (start && !busy) begin
        vigenere_apply(active_cmd);
        start_v = 1'b0;
      end
      if (!start_v && pending_cmds.size() > 0) begin
        if (pending_cmds[0].drain &&
            (expected_ciphers.size() != 0 || busy || strobe)) begin
          start_v = 1'b0;
        end else if ($urandom_range(99, 0) >= pending_cmds[0].idle_pct) begin
          active_cmd = pending_cmds.pop_front();
          action <= active_cmd.act;
          letter <= active_cmd.ltr;
          start_v = 1'b1;
        end
      end
      start <= start_v;
    end
  end

  // Monitor: a strobed result is taken at the edge that ends its cycle.
  always @(posedge clk) begin : check_results
    cipher_result_t want;
    if (!rst && strobe) begin
      if (expected_ciphers.size() == 0) begin
        $error("unexpected result: cipher_letter=%0d status=%0d", cipher_letter, status);
        fail_count++;
      end else begin
        want = expected_ciphers.pop_front();
        if (cipher_letter !== want.cipher) begin
          $error("cipher_letter mismatch: expected %0d, actual %0d", want.cipher,
                 cipher_letter);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("keyed_vigenere_encryptor_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned p;
    clear_cipher_state();

    // Directed items: empty keystream, keyword repeats and bad letters,
    // out-of-range keystream and plaintext letters, key ring wrap, clear.
    stage(ACT_ENCRYPT, 5'd0);
    stage(ACT_KEYWORD, 5'd10);
    stage(ACT_KEYWORD, 5'd4);
    stage(ACT_KEYWORD, 5'd24);
    stage(ACT_KEYWORD, 5'd4);
    stage(ACT_KEYWORD, 5'd31);
    stage(ACT_KEYWORD, 5'd0);
    stage(ACT_KEYSTRM, 5'd0);
    stage(ACT_KEYSTRM, 5'd25);
    stage(ACT_KEYSTRM, 5'd31);
    stage(ACT_ENCRYPT, 5'd0);
    stage(ACT_ENCRYPT, 5'd25);
    stage(ACT_ENCRYPT, 5'd31);
    stage(ACT_ENCRYPT, 5'd13);
    stage(ACT_ENCRYPT, 5'd7);
    stage(ACT_CLEAR, 5'd0);
    stage(ACT_ENCRYPT, 5'd25);
    stage(ACT_CLEAR, 5'd31);
    stage(ACT_KEYSTRM, 5'd13);
    stage(ACT_ENCRYPT, 5'd30);

    while (staged_cmds.size() < NUM_ITEMS) stage_random_sequence();

    // Three idle profiles; each opens by waiting for all results to drain.
    n = staged_cmds.size();
    foreach (staged_cmds[i]) begin
      p = (i * 3) / n;
      staged_cmds[i].idle_pct = (p == 0) ? 20 : (p == 1) ? 49 : 0;
      staged_cmds[i].drain = (i == 0) || ((i * 3) / n != ((i - 1) * 3) / n);
    end
    pending_cmds = staged_cmds;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sampled on the falling edge so that start has settled after the driver.
    while (pending_cmds.size() != 0 || start) @(negedge clk);
    while (expected_ciphers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("keyed_vigenere_encryptor_unit_tb: PASS");
    end else begin
      $display("keyed_vigenere_encryptor_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
